@@ rtl/aes_pkg.sv @@
// Package with types, constants and byte functions shared by the AES block cipher modules.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int RoundKeyWords = 60;
    localparam int RkAddrW = $clog2(RoundKeyWords);

    typedef enum logic [2:0] {
        MODE_ECB_ENC = 3'd0,
        MODE_ECB_DEC = 3'd1,
        MODE_CBC_ENC = 3'd2,
        MODE_CBC_DEC = 3'd3,
        MODE_CTR     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_KLEN = 3'd4,
        REG_MODE = 3'd5,
        REG_IVH  = 3'd6,
        REG_IVL  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic       take_input;
        logic       expand_start;
        logic       expand_step;
        logic       load_block;
        logic       round_step;
        logic       finish;
        logic [3:0] round_num;
        logic       last_round;
        logic [3:0] key_round;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic first_block;
        logic expand_done;
        logic decrypt;
        logic [3:0] rounds;
    } dp_status_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

@@ rtl/aes_key_exp.sv @@
// Key expansion unit: one round key word per cycle, while step is asserted, into the round key memory.
`timescale 1ns / 1ps
module aes_key_exp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         step,
    input  logic [255:0]                 key,
    input  logic [1:0]                   key_length,
    input  logic [aes_pkg::RkAddrW-1:0]  rd_addr,
    output logic [31:0]                  rd_data,
    output logic                         done
);
    logic [31:0] rk_mem [aes_pkg::RoundKeyWords];
    logic [31:0] win_reg [8];
    logic [31:0] win_next [8];
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  rc_reg, rc_next;
    logic [5:0]  total;
    logic [3:0]  nk;
    logic [31:0] t_word, new_word;

    function automatic logic [31:0] sub_word_rot(input logic [31:0] w);
        return aes_pkg::sub_word({w[23:0], w[31:24]});
    endfunction

    always_comb begin
        unique case (key_length)
            2'd0:    begin nk = 4'd4; total = 6'd44; end
            2'd1:    begin nk = 4'd6; total = 6'd52; end
            default: begin nk = 4'd8; total = 6'd60; end
        endcase
    end

    // Window holds the last nk words; win_reg[nk-1] is the newest.
    always_comb begin
        t_word = win_reg[nk[2:0] - 3'd1];
        if (pos_reg == 3'd0) begin
            t_word = sub_word_rot(t_word) ^ {rc_reg, 24'd0};
        end else if (nk == 4'd8 && pos_reg == 3'd4) begin
            t_word = aes_pkg::sub_word(t_word);
        end
        new_word = win_reg[0] ^ t_word;
        for (int i = 0; i < 8; i++) begin
            win_next[i] = (i < 7) ? win_reg[i + 1] : 32'd0;
        end
        win_next[nk[2:0] - 3'd1] = new_word;
        pos_next = (pos_reg == nk[2:0] - 3'd1) ? 3'd0 : pos_reg + 3'd1;
        rc_next  = (pos_reg == 3'd0) ? aes_pkg::xtime(rc_reg) : rc_reg;
        idx_next = idx_reg + 6'd1;
    end

    assign done = (idx_reg >= total);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 6'd60;
            pos_reg <= 3'd0;
            rc_reg  <= 8'h01;
        end else if (start) begin
            idx_reg <= 6'd0;
            pos_reg <= 3'd0;
            rc_reg  <= 8'h01;
        end else if (step && !done) begin
            if (idx_reg >= {2'd0, nk}) begin
                pos_reg <= pos_next;
                rc_reg  <= rc_next;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 8; i++) begin
                win_reg[i] <= key[255 - 32*i -: 32];
            end
        end else if (step && !done && idx_reg >= {2'd0, nk}) begin
            win_reg <= win_next;
        end
        if (step && !done) begin
            rk_mem[idx_reg[aes_pkg::RkAddrW-1:0]] <=
                (idx_reg < {2'd0, nk}) ? key[255 - 32*idx_reg[2:0] -: 32] : new_word;
        end
        rd_data <= rk_mem[rd_addr];
    end
endmodule

@@ rtl/aes_datapath.sv @@
// Datapath: configuration registers, state register, shared round unit and mode logic.
`timescale 1ns / 1ps
module aes_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic [127:0]            in_data,
    input  logic                    in_first,
    input  logic [4:0]              in_count,
    input  aes_pkg::dp_cmd_t        cmd,
    output aes_pkg::dp_status_t     status,
    output logic [127:0]            result
);
    logic [63:0]  key_reg [4];
    logic [1:0]   klen_reg;
    logic [2:0]   mode_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] blk_reg, state_reg, state_next;
    logic         first_reg;
    logic [4:0]   count_reg;
    logic [127:0] result_reg, result_next;
    logic [127:0] rk;
    logic [31:0]  rk_word;
    logic [1:0]   col_reg;
    logic         done;
    logic         dec;
    logic [aes_pkg::RkAddrW-1:0] rd_addr;
    logic [127:0] rk_buf_reg;

    assign dec = (mode_reg == aes_pkg::MODE_ECB_DEC) || (mode_reg == aes_pkg::MODE_CBC_DEC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            klen_reg <= '0;
            mode_reg <= '0;
            iv_reg   <= '0;
        end else if (cfg_we) begin
            unique case (aes_pkg::reg_index_t'(cfg_index))
                aes_pkg::REG_KEY0: key_reg[0] <= cfg_data;
                aes_pkg::REG_KEY1: key_reg[1] <= cfg_data;
                aes_pkg::REG_KEY2: key_reg[2] <= cfg_data;
                aes_pkg::REG_KEY3: key_reg[3] <= cfg_data;
                aes_pkg::REG_KLEN: klen_reg <= cfg_data[1:0];
                aes_pkg::REG_MODE: mode_reg <= cfg_data[2:0];
                aes_pkg::REG_IVH:  iv_reg[127:64] <= cfg_data;
                aes_pkg::REG_IVL:  iv_reg[63:0] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Round keys are read one word a cycle; four words gathered per round.
    assign rd_addr = aes_pkg::RkAddrW'({cmd.key_round, col_reg});

    aes_key_exp u_kexp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.expand_start),
        .step       (cmd.expand_step),
        .key        ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .key_length (klen_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rk_word),
        .done       (done)
    );

    always_comb begin
        rk = rk_buf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (cmd.load_block) begin
            col_reg <= col_reg + 2'd1;
        end else begin
            col_reg <= '0;
        end
    end

    // load_block spans four reads, each word arriving from the registered read port in the cycle after its read.
    logic [2:0] lcnt_reg;
    logic [1:0] wsel;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg <= '0;
        end else begin
            lcnt_reg <= cmd.load_block ? lcnt_reg + 3'd1 : 3'd0;
        end
    end
    assign wsel = lcnt_reg[1:0] - 2'd1;
    always_ff @(posedge aclk) begin
        if (cmd.load_block && lcnt_reg != 3'd0) begin
            rk_buf_reg[127 - 32*wsel -: 32] <= rk_word;
        end
    end

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = aes_pkg::sbox(s[127 - 8*i -: 8]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4*c] = b[r + 4*((c + r) % 4)];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!last) begin
                t[4*c]   = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
                t[4*c+3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                b[r + 4*((c + r) % 4)] = s[127 - 8*(r + 4*c) -: 8];
        for (int i = 0; i < 16; i++) t[i] = aes_pkg::inv_sbox(b[i]) ^ k[127 - 8*i -: 8];
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                x0 = aes_pkg::xtime(a0); x1 = aes_pkg::xtime(a1);
                x2 = aes_pkg::xtime(a2); x3 = aes_pkg::xtime(a3);
                y0 = aes_pkg::xtime(x0); y1 = aes_pkg::xtime(x1);
                y2 = aes_pkg::xtime(x2); y3 = aes_pkg::xtime(x3);
                z0 = aes_pkg::xtime(y0); z1 = aes_pkg::xtime(y1);
                z2 = aes_pkg::xtime(y2); z3 = aes_pkg::xtime(y3);
                // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1.
                t[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
                t[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
                t[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
                t[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
            end
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
        return o;
    endfunction

    logic [127:0] ctr_mask;
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            ctr_mask[127 - 8*i -: 8] = (5'(i) < count_reg) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        result_next = result_reg;
        if (cmd.take_input && in_first) begin
            chain_next = iv_reg;
        end
        if (cmd.round_step) begin
            if (cmd.round_num == 4'd0) begin
                unique case (mode_reg)
                    aes_pkg::MODE_CBC_ENC: state_next = blk_reg ^ chain_reg ^ rk;
                    aes_pkg::MODE_CTR:     state_next = chain_reg ^ rk;
                    default:               state_next = blk_reg ^ rk;
                endcase
            end else if (dec) begin
                state_next = inv_round(state_reg, rk, cmd.last_round);
            end else begin
                state_next = fwd_round(state_reg, cmd.last_round) ^ rk;
            end
        end
        if (cmd.finish) begin
            unique case (mode_reg)
                aes_pkg::MODE_ECB_ENC, aes_pkg::MODE_ECB_DEC: result_next = state_reg;
                aes_pkg::MODE_CBC_ENC: begin
                    result_next = state_reg;
                    chain_next  = state_reg;
                end
                aes_pkg::MODE_CBC_DEC: begin
                    result_next = state_reg ^ chain_reg;
                    chain_next  = blk_reg;
                end
                aes_pkg::MODE_CTR: begin
                    result_next = (blk_reg ^ state_reg) & ctr_mask;
                    chain_next  = chain_reg + 128'd1;
                end
                default: result_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_input) begin
            blk_reg   <= in_data;
            first_reg <= in_first;
            count_reg <= in_count;
        end
        state_reg  <= state_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign status.first_block = first_reg;
    assign status.expand_done = done;
    assign status.decrypt     = dec;
    assign status.rounds      = (klen_reg == 2'd0) ? 4'd10 : (klen_reg == 2'd1) ? 4'd12 : 4'd14;
endmodule

@@ rtl/aes_ctrl.sv @@
// Controller state machine sequencing key expansion, round key loads and rounds.
`timescale 1ns / 1ps
module aes_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  aes_pkg::dp_status_t status,
    output aes_pkg::dp_cmd_t    cmd
);
    aes_pkg::state_t state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic [2:0] lcnt_reg, lcnt_next;
    logic       expand_go_reg, expand_go_next;
    logic [3:0] step_num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aes_pkg::ST_IDLE;
            round_reg     <= '0;
            lcnt_reg      <= '0;
            expand_go_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            lcnt_reg      <= lcnt_next;
            expand_go_reg <= expand_go_next;
        end
    end

    // Steps count 0..rounds; decryption walks the key schedule backward.
    assign step_num = round_reg;

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        lcnt_next      = lcnt_reg;
        expand_go_next = 1'b0;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.round_num  = step_num;
        cmd.last_round = (step_num == status.rounds);
        cmd.key_round  = status.decrypt ? status.rounds - step_num : step_num;
        unique case (state_reg)
            aes_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take_input = 1'b1;
                    round_next     = '0;
                    state_next     = aes_pkg::ST_EXPAND;
                end
            end
            aes_pkg::ST_EXPAND: begin
                if (status.first_block && !expand_go_reg) begin
                    cmd.expand_start = 1'b1;
                    expand_go_next   = 1'b1;
                end else if (status.first_block && !status.expand_done) begin
                    cmd.expand_step = 1'b1;
                    expand_go_next  = 1'b1;
                end else begin
                    lcnt_next  = '0;
                    state_next = aes_pkg::ST_LOAD;
                end
            end
            aes_pkg::ST_LOAD: begin
                cmd.load_block = 1'b1;
                lcnt_next      = lcnt_reg + 3'd1;
                if (lcnt_reg == 3'd4) begin
                    lcnt_next  = '0;
                    state_next = aes_pkg::ST_ROUND;
                end
            end
            aes_pkg::ST_ROUND: begin
                cmd.round_step = 1'b1;
                round_next     = round_reg + 4'd1;
                state_next     = (step_num == status.rounds) ? aes_pkg::ST_FINISH
                                                              : aes_pkg::ST_LOAD;
            end
            aes_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = aes_pkg::ST_OUT;
            end
            aes_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = aes_pkg::ST_IDLE;
            end
            default: state_next = aes_pkg::ST_IDLE;
        endcase
    end
endmodule

@@ rtl/aes_block_cipher_modes.sv @@
// Top level of the AES block cipher with ECB, CBC and CTR modes.
`timescale 1ns / 1ps
// One 16-byte word in, one out, with one word in flight at a time. The next input word
// can be taken in the cycle after the result leaves: one shared round unit, and four round
// key words read from the single read port of the round key memory before each round. A
// word with first_block set first expands the key, one round key word a cycle.
module aes_block_cipher_modes (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // data_high, data_low, byte_count, zero padding
    input  logic          s_tuser,   // first_block
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // result_high, result_low
);
    aes_pkg::dp_cmd_t    cmd;
    aes_pkg::dp_status_t status;
    logic [127:0]        result;

    aes_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    aes_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   ({s_tdata[63:0], s_tdata[127:64]}),
        .in_first  (s_tuser),
        .in_count  (s_tdata[132:128]),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_tdata = {result[63:0], result[127:64]};
endmodule

@@ rtl/aes_checker.sv @@
// Port checker for the AES block cipher top level, bound to it.
`timescale 1ns / 1ps
module aes_port_sva (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind aes_block_cipher_modes aes_port_sva u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
